@@ src/pps_pkg.sv @@
// pps_pkg: shared constants and types of the pointer position smoother.
// No dependencies.
package pps_pkg;

    localparam int CHANNELS  = 4;
    localparam int FRAC_BITS = 12;
    localparam int CH_W      = 2;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_SENS   = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // shared unit operations
    typedef enum logic [2:0] {
        OP_MUL  = 3'b001,
        OP_DIV  = 3'b010,
        OP_SQRT = 3'b100
    } op_t;

    typedef struct packed {
        logic        start;
        op_t         op;
        logic [33:0] a;
        logic [33:0] b;
    } unit_req_t;

    typedef struct packed {
        logic        done;
        logic [33:0] result;
    } unit_rsp_t;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767)
            return 16'sh7fff;
        else if (v < -19'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

endpackage

@@ src/pps_unit.sv @@
// pps_unit: shared multi-cycle arithmetic unit: multiply, restoring divide, square root.
// Depends on pps_pkg.
module pps_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  pps_pkg::unit_req_t req,
    output pps_pkg::unit_rsp_t rsp
);

    logic        busy_reg, busy_next;
    pps_pkg::op_t op_reg, op_next;
    logic [33:0] a_reg, a_next;     // dividend / radicand, shifted out
    logic [33:0] b_reg, b_next;     // divisor
    logic [35:0] rem_reg, rem_next;
    logic [33:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [35:0] trial;
    logic [35:0] rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_sh    = '0;
        trial     = '0;
        if (req.start)
        begin
            op_next  = req.op;
            a_next   = req.a;
            b_next   = req.b;
            rem_next = '0;
            q_next   = '0;
            cnt_next = (req.op == pps_pkg::OP_SQRT) ? 6'd17 :
                       (req.op == pps_pkg::OP_DIV) ? 6'd34 : 6'd1;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                pps_pkg::OP_MUL:
                begin
                    q_next = a_reg[16:0] * b_reg[16:0];
                end
                pps_pkg::OP_DIV:
                begin
                    rem_sh = {rem_reg[34:0], a_reg[33]};
                    a_next = {a_reg[32:0], 1'b0};
                    trial  = rem_sh - {2'b0, b_reg};
                    if (!trial[35])
                    begin
                        rem_next = trial;
                        q_next   = {q_reg[32:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        q_next   = {q_reg[32:0], 1'b0};
                    end
                end
                pps_pkg::OP_SQRT:
                begin
                    // two radicand bits per step
                    rem_sh = {rem_reg[33:0], a_reg[33:32]};
                    a_next = {a_reg[31:0], 2'b0};
                    trial  = rem_sh - {q_reg[33:0], 2'b01};
                    if (!trial[35])
                    begin
                        rem_next = trial;
                        q_next   = {q_reg[32:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        q_next   = {q_reg[32:0], 1'b0};
                    end
                end
                default:
                begin
                    q_next = '0;
                end
            endcase
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= pps_pkg::OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = q_reg;

    property p_done_after_busy;
        @(posedge clk) disable iff (!rst_n) done_reg |-> $past(busy_reg);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy)
        else $error("done without busy");

    property p_no_start_busy;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> !req.start;
    endproperty
    a_no_start_busy: assert property (p_no_start_busy)
        else $error("start while unit busy");

    property p_done_pulse;
        @(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg;
    endproperty
    a_done_pulse: assert property (p_done_pulse)
        else $error("done held");

endmodule

@@ src/pps_seq.sv @@
// pps_seq: sequencer that walks one sample through the shared unit, holds channel state.
// Depends on pps_pkg.
module pps_seq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         channel,
    input  logic               connected,
    input  logic               pointer_valid,
    input  logic signed [15:0] pointer_x,
    input  logic signed [15:0] pointer_y,
    input  logic [14:0]        smooth_radius,
    input  logic [12:0]        smooth_sensitivity,
    input  logic signed [15:0] sensor_height,
    output logic               busy,
    output logic               done,
    output logic [80:0]        result,
    output pps_pkg::unit_req_t req,
    input  pps_pkg::unit_rsp_t rsp
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PREP  = 11'b00000000010,
        S_DIV   = 11'b00000000100,
        S_F2    = 11'b00000001000,
        S_F4    = 11'b00000010000,
        S_G     = 11'b00000100000,
        S_STEP  = 11'b00001000000,
        S_MOVE  = 11'b00010000000,
        S_MOVEY = 11'b00100000000,
        S_SQRT  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic               track_reg [pps_pkg::CHANNELS];
    logic signed [15:0] lastx_reg [pps_pkg::CHANNELS];
    logic signed [15:0] lasty_reg [pps_pkg::CHANNELS];

    logic [1:0]         ch_reg;
    logic               axis_reg;          // 0 = X, 1 = Y
    logic signed [15:0] tx_reg, ty_reg;    // targets
    logic signed [15:0] last_reg;
    logic signed [16:0] d_reg;
    logic [16:0]        mag_reg;
    logic [12:0]        g_reg;
    logic signed [15:0] ox_reg, oy_reg;
    logic signed [15:0] mx_reg, my_reg;
    logic [33:0]        sq_reg;
    logic               pend_reg;
    logic [80:0]        res_reg;
    logic               done_reg;

    logic signed [17:0] ysum;
    logic [12:0]        gcl;
    logic signed [18:0] stepped;
    logic signed [15:0] onew;
    logic signed [16:0] mv;
    logic signed [15:0] mvs;

    assign ysum  = 18'(pointer_y) + 18'(sensor_height);
    assign gcl   = (smooth_sensitivity > 13'd4096) ? 13'd4096 : smooth_sensitivity;

    always_comb
    begin
        req       = '0;
        req.op    = pps_pkg::OP_MUL;
        state_next = state_reg;
        stepped   = d_reg[16] ? 19'(last_reg) - 19'(rsp.result[29:12])
                              : 19'(last_reg) + 19'(rsp.result[29:12]);
        onew      = pps_pkg::sat16(stepped);
        mv        = 17'(onew) - 17'(last_reg);
        mvs       = pps_pkg::sat16(19'(mv));
        case (state_reg)
            S_IDLE:
            begin
                if (pend_reg)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                if (smooth_radius != 15'd0 && mag_reg < 17'(smooth_radius))
                begin
                    req.start = 1'b1;
                    req.op    = pps_pkg::OP_DIV;
                    req.a     = 34'(mag_reg) << pps_pkg::FRAC_BITS;
                    req.b     = 34'(smooth_radius);
                    state_next = S_DIV;
                end
                else
                begin
                    req.start = 1'b1;
                    req.a     = 34'(g_reg);
                    req.b     = 34'(mag_reg);
                    state_next = S_STEP;
                end
            end
            S_DIV:
            begin
                if (rsp.done)
                begin
                    req.start = 1'b1;
                    req.a     = 34'(rsp.result[16:0]);
                    req.b     = 34'(rsp.result[16:0]);
                    state_next = S_F2;
                end
            end
            S_F2:
            begin
                if (rsp.done)
                begin
                    req.start = 1'b1;
                    req.a     = 34'(rsp.result[28:12]);
                    req.b     = 34'(rsp.result[28:12]);
                    state_next = S_F4;
                end
            end
            S_F4:
            begin
                if (rsp.done)
                begin
                    req.start = 1'b1;
                    req.a     = 34'(g_reg);
                    req.b     = 34'(rsp.result[28:12]);
                    state_next = S_G;
                end
            end
            S_G:
            begin
                if (rsp.done)
                begin
                    req.start = 1'b1;
                    req.a     = 34'(rsp.result[24:12]);
                    req.b     = 34'(mag_reg);
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (rsp.done)
                    state_next = axis_reg ? S_MOVE : S_PREP;
            end
            S_MOVE:
            begin
                // mx^2 ready, square my next
                if (rsp.done)
                begin
                    req.start = 1'b1;
                    req.a     = 34'(my_reg[15] ? -17'(my_reg) : 17'(my_reg));
                    req.b     = req.a;
                    state_next = S_MOVEY;
                end
            end
            S_MOVEY:
            begin
                if (rsp.done)
                begin
                    req.start = 1'b1;
                    req.op    = pps_pkg::OP_SQRT;
                    req.a     = sq_reg + rsp.result;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (rsp.done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // squares of moves are taken with the unit after STEP of Y
        if (state_reg == S_STEP && rsp.done && axis_reg)
        begin
            req.start = 1'b1;
            req.op    = pps_pkg::OP_MUL;
            req.a     = 34'(mx_reg[15] ? -17'(mx_reg) : 17'(mx_reg));
            req.b     = req.a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            for (int i = 0; i < pps_pkg::CHANNELS; i++)
            begin
                track_reg[i] <= 1'b0;
                lastx_reg[i] <= '0;
                lasty_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            state_reg <= state_next;
            if (start)
            begin
                if (!connected || !pointer_valid)
                begin
                    track_reg[channel] <= 1'b0;
                    lastx_reg[channel] <= '0;
                    lasty_reg[channel] <= '0;
                    done_reg <= 1'b1;
                end
                else if (!track_reg[channel])
                begin
                    track_reg[channel] <= 1'b1;
                    lastx_reg[channel] <= pointer_x;
                    lasty_reg[channel] <= pps_pkg::sat16(19'(ysum));
                    done_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b1;
                end
            end
            if (state_reg == S_IDLE && pend_reg)
                pend_reg <= 1'b0;
            if (state_reg == S_SQRT && rsp.done)
            begin
                lastx_reg[ch_reg] <= ox_reg;
                lasty_reg[ch_reg] <= oy_reg;
            end
            if (state_reg == S_DONE)
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ch_reg   <= channel;
            tx_reg   <= pointer_x;
            ty_reg   <= pps_pkg::sat16(19'(ysum));
            axis_reg <= 1'b0;
            if (!connected || !pointer_valid)
                res_reg <= '0;
            else
                res_reg <= {16'd0, 16'd0, 16'd0, pps_pkg::sat16(19'(ysum)),
                            pointer_x, 1'b1};
        end
        if (state_reg == S_IDLE && pend_reg)
        begin
            last_reg <= lastx_reg[ch_reg];
            d_reg    <= 17'(tx_reg) - 17'(lastx_reg[ch_reg]);
            mag_reg  <= (17'(tx_reg) - 17'(lastx_reg[ch_reg])) < 0
                        ? 17'(-(17'(tx_reg) - 17'(lastx_reg[ch_reg])))
                        : 17'(17'(tx_reg) - 17'(lastx_reg[ch_reg]));
            g_reg    <= gcl;
        end
        if (state_reg == S_STEP && rsp.done)
        begin
            if (!axis_reg)
            begin
                ox_reg   <= onew;
                mx_reg   <= mvs;
                axis_reg <= 1'b1;
                last_reg <= lasty_reg[ch_reg];
                d_reg    <= 17'(ty_reg) - 17'(lasty_reg[ch_reg]);
                mag_reg  <= (17'(ty_reg) - 17'(lasty_reg[ch_reg])) < 0
                            ? 17'(-(17'(ty_reg) - 17'(lasty_reg[ch_reg])))
                            : 17'(17'(ty_reg) - 17'(lasty_reg[ch_reg]));
            end
            else
            begin
                oy_reg <= onew;
                my_reg <= mvs;
            end
        end
        if (state_reg == S_MOVE && rsp.done)
            sq_reg <= rsp.result;
        if (state_reg == S_SQRT && rsp.done)
            res_reg <= {rsp.result[15:0], my_reg, mx_reg, oy_reg, ox_reg, 1'b1};
    end

    assign busy   = pend_reg || (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    property p_done_idle;
        @(posedge clk) disable iff (!rst_n) done_reg |-> state_reg == S_IDLE;
    endproperty
    a_done_idle: assert property (p_done_idle)
        else $error("done outside idle");

    property p_no_start_busy;
        @(posedge clk) disable iff (!rst_n) start |-> !busy;
    endproperty
    a_no_start_busy: assert property (p_no_start_busy)
        else $error("sample accepted while sequencer busy");

    property p_state_onehot;
        @(posedge clk) disable iff (!rst_n) $onehot(state_reg);
    endproperty
    a_state_onehot: assert property (p_state_onehot)
        else $error("state not one-hot");

endmodule

@@ src/pointer_position_smoother.sv @@
// pointer_position_smoother: top level, stream ports, configuration registers, output slot.
// Depends on pps_pkg, pps_seq, pps_unit.
//
// Usage:
//  - s_axis carries one pointer sample per transfer; m_axis returns exactly one result.
//  - cfg_we/cfg_index/cfg_wdata write smoothing radius, sensitivity and sensor height;
//    write only while idle.
//  - Untracked, invalid or disconnected samples bypass the shared unit: done is registered, then the output valid.
//  - A tracked sample runs both axes and the speed through one shared unit:
//    per axis up to 34 divide steps plus four multiplies, then two squares and a
//    17-step square root.
//  - s_axis_tready is low while a sample is in work or a result waits in the slot;
//    the next sample can transfer at the edge after the result transfer.
//  - A stalled receiver holds the result in the output register; nothing is lost.
//  - Reset clears tracking of all channels and restores the register defaults.
module pointer_position_smoother
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] channel, [2] connected, [3] pointer_valid, [19:4] pointer_x, [35:20] pointer_y
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] pos_valid, [16:1] pos_x, [32:17] pos_y, [48:33] move_x, [64:49] move_y,
    // [80:65] move_speed
    output logic [87:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [14:0]        radius_reg;
    logic [12:0]        sens_reg;
    logic signed [15:0] height_reg;
    logic               ovalid_reg;
    logic               start;
    logic               busy;
    logic               done;
    logic [80:0]        result;
    pps_pkg::unit_req_t req;
    pps_pkg::unit_rsp_t rsp;

    assign start = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !busy && !ovalid_reg && !done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            sens_reg   <= 13'd4096;
            height_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pps_pkg::REG_RADIUS: radius_reg <= cfg_wdata[14:0];
                    pps_pkg::REG_SENS:   sens_reg   <= cfg_wdata[12:0];
                    pps_pkg::REG_HEIGHT: height_reg <= cfg_wdata;
                    default:             ;
                endcase
            end
            if (done)
                ovalid_reg <= 1'b1;
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    pps_seq u_seq
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .channel            (s_axis_tdata[1:0]),
        .connected          (s_axis_tdata[2]),
        .pointer_valid      (s_axis_tdata[3]),
        .pointer_x          (s_axis_tdata[19:4]),
        .pointer_y          (s_axis_tdata[35:20]),
        .smooth_radius      (radius_reg),
        .smooth_sensitivity (sens_reg),
        .sensor_height      (height_reg),
        .busy               (busy),
        .done               (done),
        .result             (result),
        .req                (req),
        .rsp                (rsp)
    );

    pps_unit u_unit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {7'd0, result};

    property p_done_slot_free;
        @(posedge clk) disable iff (!rst_n) done |-> !ovalid_reg;
    endproperty
    a_done_slot_free: assert property (p_done_slot_free)
        else $error("result overwrote pending output");

    property p_result_held;
        @(posedge clk) disable iff (!rst_n)
            (ovalid_reg && !m_axis_tready) |=> $stable(result);
    endproperty
    a_result_held: assert property (p_result_held)
        else $error("result changed while stalled");

    property p_no_accept_pending;
        @(posedge clk) disable iff (!rst_n) ovalid_reg |-> !s_axis_tready;
    endproperty
    a_no_accept_pending: assert property (p_no_accept_pending)
        else $error("input accepted with result pending");

endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for pointer_position_smoother.
// Drives pointer samples and register writes, predicts every result and checks it.
// Depends on pps_pkg and the pointer_position_smoother RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]         channel;
        logic               connected;
        logic               pointer_valid;
        logic signed [15:0] pointer_x;
        logic signed [15:0] pointer_y;
    } sample_t;

    typedef struct {
        logic               pos_valid;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic [15:0]        move_speed;
    } pointer_out_t;

    localparam int LIMIT = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = pps_pkg::REG_RADIUS;
    logic [15:0] cfg_wdata = '0;
    // ready captured at the rising edge, so acceptance is judged on sampled values
    logic        s_axis_tready_q = 1'b0;

    pointer_position_smoother dut (.*);

    always #6 clk = ~clk;

    // predictor state: registers and per-channel tracking
    logic [14:0]        radius_q;
    logic [12:0]        sens_q;
    logic signed [15:0] height_q;
    logic               tracking [pps_pkg::CHANNELS];
    logic signed [15:0] prev_x [pps_pkg::CHANNELS];
    logic signed [15:0] prev_y [pps_pkg::CHANNELS];

    sample_t      pending_samples[$];
    pointer_out_t expected_positions[$];
    int           mismatches = 0;
    int           checked = 0;
    int           cycles = 0;
    bit           calm = 1'b0;     // no idling in the final stretch
    int           in_gap = 0;
    int           out_gap = 0;

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint root_floor(input longint n);
        longint r;
        r = 0;
        for (int b = 16; b >= 0; b--)
        begin
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
                r += longint'(1) << b;
        end
        return r;
    endfunction

    // one axis: move from last toward target by gain * delta, dead zone quartic
    function automatic logic signed [15:0] follow_axis(input logic signed [15:0] last,
                                                       input logic signed [15:0] target);
        longint d, mag, g, f, f2, f4, stp;
        d   = longint'(target) - longint'(last);
        mag = d < 0 ? -d : d;
        g   = sens_q > 4096 ? 4096 : sens_q;
        if (radius_q != 0 && mag < radius_q)
        begin
            f  = (mag << pps_pkg::FRAC_BITS) / radius_q;
            f2 = (f * f) >> pps_pkg::FRAC_BITS;
            f4 = (f2 * f2) >> pps_pkg::FRAC_BITS;
            g  = (g * f4) >> pps_pkg::FRAC_BITS;
        end
        stp = (g * mag) >> pps_pkg::FRAC_BITS;
        return clamp16(d < 0 ? longint'(last) - stp : longint'(last) + stp);
    endfunction

    function automatic pointer_out_t predict_position(input sample_t s);
        pointer_out_t r;
        logic signed [15:0] ox, oy, mx, my;
        int c;
        c  = int'(s.channel);
        r  = '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0};
        ox = s.pointer_x;
        oy = clamp16(longint'(s.pointer_y) + longint'(height_q));
        mx = '0;
        my = '0;
        if (!s.connected || !s.pointer_valid)
        begin
            tracking[c] = 1'b0;
            prev_x[c]   = '0;
            prev_y[c]   = '0;
            return r;
        end
        if (tracking[c])
        begin
            ox = follow_axis(prev_x[c], s.pointer_x);
            oy = follow_axis(prev_y[c], oy);
            mx = clamp16(longint'(ox) - longint'(prev_x[c]));
            my = clamp16(longint'(oy) - longint'(prev_y[c]));
            r.move_speed = 16'(root_floor(longint'(mx) * mx + longint'(my) * my));
        end
        tracking[c] = 1'b1;
        prev_x[c]   = ox;
        prev_y[c]   = oy;
        r.pos_valid = 1'b1;
        r.pos_x     = ox;
        r.pos_y     = oy;
        r.move_x    = mx;
        r.move_y    = my;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
    endtask

    // driver: one sample per transfer, random gaps; prediction at acceptance
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready_q)
            begin
                expected_positions.push_back(predict_position(pending_samples.pop_front()));
            end
            if (!(s_axis_tvalid && !s_axis_tready_q))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    in_gap = $urandom_range(1, 8);
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'd0, pending_samples[0].pointer_y,
                                      pending_samples[0].pointer_x,
                                      pending_samples[0].pointer_valid,
                                      pending_samples[0].connected,
                                      pending_samples[0].channel};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            // receiver stalls
            if (out_gap > 0)
            begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_gap = $urandom_range(1, 8);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
        s_axis_tready_q <= s_axis_tready;

    // monitor
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            pointer_out_t e;
            if (expected_positions.size() == 0)
            begin
                report_mismatch("unexpected result", m_axis_tdata[15:0], 16'h0000);
            end
            else
            begin
                e = expected_positions.pop_front();
                if (m_axis_tdata[0] !== e.pos_valid)
                    report_mismatch("pos_valid", 16'(m_axis_tdata[0]), 16'(e.pos_valid));
                if (m_axis_tdata[16:1] !== e.pos_x)
                    report_mismatch("pos_x", m_axis_tdata[16:1], e.pos_x);
                if (m_axis_tdata[32:17] !== e.pos_y)
                    report_mismatch("pos_y", m_axis_tdata[32:17], e.pos_y);
                if (m_axis_tdata[48:33] !== e.move_x)
                    report_mismatch("move_x", m_axis_tdata[48:33], e.move_x);
                if (m_axis_tdata[64:49] !== e.move_y)
                    report_mismatch("move_y", m_axis_tdata[64:49], e.move_y);
                if (m_axis_tdata[80:65] !== e.move_speed)
                    report_mismatch("move_speed", m_axis_tdata[80:65], e.move_speed);
                checked++;
            end
        end
        if (cycles > LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            pps_pkg::REG_RADIUS: radius_q = val[14:0];
            pps_pkg::REG_SENS:   sens_q   = val[12:0];
            default:             height_q = val;
        endcase
    endtask

    task automatic queue_sample(input int ch, input bit conn, input bit pv,
                                input int x, input int y);
        sample_t s;
        s.channel       = 2'(ch);
        s.connected     = conn;
        s.pointer_valid = pv;
        s.pointer_x     = 16'(x);
        s.pointer_y     = 16'(y);
        pending_samples.push_back(s);
    endtask

    // wait until everything queued has been answered, then let the block settle
    task automatic drain;
        while (pending_samples.size() != 0 || expected_positions.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // a run of tracked samples on one channel, wandering near a start point
    task automatic queue_track(input int len);
        int ch, x, y, spread;
        ch = $urandom_range(0, 3);
        x  = $urandom_range(0, 65535) - 32768;
        y  = $urandom_range(0, 65535) - 32768;
        spread = (1 << $urandom_range(2, 16)) - 1;
        for (int k = 0; k < len; k++)
        begin
            x = int'(clamp16(x + int'($urandom_range(0, 2 * spread)) - spread));
            y = int'(clamp16(y + int'($urandom_range(0, 2 * spread)) - spread));
            queue_sample(ch, 1, 1, x, y);
        end
    endtask

    initial
    begin
        int settings [5][3];
        radius_q = 0;
        sens_q   = 4096;
        height_q = 0;
        for (int c = 0; c < pps_pkg::CHANNELS; c++)
        begin
            tracking[c] = 1'b0;
            prev_x[c]   = '0;
            prev_y[c]   = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset defaults, extremes, dropouts, offset overflow
        queue_sample(0, 1, 1, 0, 0);
        queue_sample(0, 1, 1, 32767, 32767);
        queue_sample(0, 1, 1, -32768, -32768);
        queue_sample(0, 1, 1, 100, -100);
        queue_sample(0, 0, 1, 5, 5);
        queue_sample(0, 1, 1, 7, 9);
        queue_sample(1, 1, 0, -1, -1);
        queue_sample(1, 1, 1, -1, -1);
        queue_sample(1, 1, 1, 32767, -32768);
        queue_sample(2, 1, 1, 21845, -21846);
        queue_sample(3, 0, 0, 32767, -32768);
        drain();
        write_reg(pps_pkg::REG_RADIUS, 16'h7fff);
        write_reg(pps_pkg::REG_SENS, 16'h1fff);
        write_reg(pps_pkg::REG_HEIGHT, 16'h7fff);
        queue_sample(2, 1, 1, 21840, 32767);
        queue_sample(2, 1, 1, 21000, -32768);
        queue_sample(2, 1, 1, 300, 1000);
        queue_sample(3, 1, 1, -32768, 32767);
        drain();
        write_reg(pps_pkg::REG_HEIGHT, 16'h8000);
        write_reg(pps_pkg::REG_RADIUS, 16'd4096);
        write_reg(pps_pkg::REG_SENS, 16'd0);
        queue_sample(3, 1, 1, 0, -32768);
        queue_sample(3, 1, 1, 4000, -100);
        queue_sample(3, 1, 1, -4000, 100);
        drain();

        // random phases over several register settings, extremes included
        settings = '{'{0, 4096, 0}, '{32767, 4096, -32768}, '{1, 2048, 32767},
                     '{8000, 8191, 300}, '{$urandom_range(0, 32767), $urandom_range(0, 8191),
                                           int'($urandom_range(0, 65535)) - 32768}};
        for (int p = 0; p < 5; p++)
        begin
            write_reg(pps_pkg::REG_RADIUS, 16'(settings[p][0]));
            write_reg(pps_pkg::REG_SENS, 16'(settings[p][1]));
            write_reg(pps_pkg::REG_HEIGHT, 16'(settings[p][2]));
            if (p == 4)
                calm = 1'b1;
            while (pending_samples.size() < 160)
            begin
                if ($urandom_range(0, 9) < 7)
                    queue_track($urandom_range(2, 12));
                else
                    queue_sample($urandom_range(0, 3), $urandom_range(0, 5) != 0,
                                 $urandom_range(0, 5) != 0,
                                 int'($urandom_range(0, 65535)) - 32768,
                                 int'($urandom_range(0, 65535)) - 32768);
            end
            drain();
        end

        $display("Covered %0d results over eight register settings, dropouts and tracking runs",
                 checked);
        $display("on all four channels with idling and stalls on both sides.");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
